@@ hdl/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg
// shared widths, register map and stream packing for the dda line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

  // field widths
  localparam int COORD_W  = 10;
  localparam int END_W    = 18;
  localparam int COLOR_W  = 24;

  // increments carry 16 fraction bits
  localparam int INC_FRAC = 16;

  // signed endpoint distance: origin << 16 needs 26 bits, plus sign
  localparam int DIFF_W   = 27;
  // scaled distance magnitude, below 2^34 for every fraction setting
  localparam int MAG_W    = 35;
  // signed position and increment
  localparam int POS_W    = 37;
  // divider iteration counter
  localparam int DCNT_W   = $clog2(MAG_W);

  // stream packing
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 48;

  // apb register map (register index is paddr[2])
  localparam int  PADDR_W     = 3;
  localparam int  PDATA_W     = 32;
  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Y = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

endpackage : dda_pkg

`default_nettype wire

@@ hdl/dda_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// dda line drawing from a programmable origin to a fixed-point endpoint
// ----------------------------------------------------------------------------
// Each input transaction carries an endpoint (end_x, end_y, FRAC_BITS fraction
// bits) and a colour. The block draws a line from the origin registers toward
// that endpoint: the step count is the integer part of the larger distance,
// capped at MAX_STEPS, and one pixel transaction per step leaves on the master
// stream, the last one flagged with tlast. A line shorter than one pixel gives
// no output. Per-axis increments come from one shared restoring divider that
// retires one quotient bit per cycle, run first for x and then for y. A line
// passes through S_DIFF, S_STEPS, S_DIVX, S_DIVY and then S_EMIT; a line
// below one pixel goes back to S_IDLE from S_STEPS. The slave side is not
// ready while a line is in work; it opens again once the last pixel is
// loaded into the output register, even if that pixel still waits to be
// taken. The user must write the origin registers through the apb port only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module dda_line_rasterizer #(
  parameter int MAX_STEPS = 64,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // end_x [17:0], end_y [35:18], pixel_color [59:36], zero [63:60]
  input  wire logic [dda_pkg::S_TDATA_W-1:0] s_tdata,
  // pixel stream
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // pixel_x [9:0], pixel_y [19:10], out_color [43:20], zero [47:44]
  output      logic [dda_pkg::M_TDATA_W-1:0] m_tdata,
  output      logic                          m_tlast,   // last_pixel
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dda_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [dda_pkg::PDATA_W-1:0]   pwdata,
  output      logic [dda_pkg::PDATA_W-1:0]   prdata,
  output      logic                          pready
);

  import dda_pkg::*;

  localparam int STEP_W   = $clog2(MAX_STEPS + 1);
  localparam int SCALE_SH = INC_FRAC - FRAC_BITS;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_STEPS = 3'd2;
  localparam logic [2:0] S_DIVX  = 3'd3;
  localparam logic [2:0] S_DIVY  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;

  // configuration registers
  coord_t origin_x;
  coord_t origin_y;

  // latched input transaction
  logic [END_W-1:0] end_x;
  logic [END_W-1:0] end_y;
  color_t           color;

  // signed distances and their magnitudes
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dx_next;
  logic signed [DIFF_W-1:0] dy_next;
  logic [DIFF_W-1:0]        adx;
  logic [DIFF_W-1:0]        ady;
  logic [DIFF_W-1:0]        big;
  logic [DIFF_W-1:0]        big_int;
  logic [STEP_W-1:0]        steps;
  logic [STEP_W-1:0]        steps_next;

  // shared divider
  logic [MAG_W-1:0]   num;
  logic [MAG_W-1:0]   num_next;
  logic [STEP_W-1:0]  rem;
  logic [STEP_W-1:0]  rem_next;
  logic [STEP_W:0]    rem_sh;
  logic [STEP_W:0]    rem_diff;
  logic               rem_ge;
  logic [DCNT_W-1:0]  dcnt;
  logic               div_neg;
  logic               div_done;
  logic [POS_W-1:0]   quot_ext;
  logic signed [POS_W-1:0] inc_val;

  // stepping
  logic signed [POS_W-1:0] xinc;
  logic signed [POS_W-1:0] yinc;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;
  logic [STEP_W-1:0]       cnt;
  logic                    out_load;
  logic                    is_last;
  coord_t                  pix_x;
  coord_t                  pix_y;

  logic cfg_wr;

  // ---------------------------------------------------------------------------
  // apb configuration port, register picked by paddr[2]
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ORIGIN_X: origin_x <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y: origin_y <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ORIGIN_X: prdata = PDATA_W'(origin_x);
      REG_ORIGIN_Y: prdata = PDATA_W'(origin_y);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // distance and step count
  // ---------------------------------------------------------------------------
  // origin moved into the endpoint's fixed-point format
  assign dx_next = $signed(DIFF_W'(end_x) - (DIFF_W'(origin_x) << FRAC_BITS));
  assign dy_next = $signed(DIFF_W'(end_y) - (DIFF_W'(origin_y) << FRAC_BITS));

  assign adx     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ady     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign big     = (adx > ady) ? adx : ady;
  assign big_int = big >> FRAC_BITS;
  // saturate at the step limit
  assign steps_next = (big_int > DIFF_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                     : big_int[STEP_W-1:0];

  // ---------------------------------------------------------------------------
  // shared restoring divider: one quotient bit per cycle, quotient shifts
  // into the numerator register from the bottom
  // ---------------------------------------------------------------------------
  assign rem_sh   = {rem, num[MAG_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, steps};
  assign rem_diff = rem_sh - {1'b0, steps};
  assign rem_next = rem_ge ? rem_diff[STEP_W-1:0] : rem_sh[STEP_W-1:0];
  assign num_next = {num[MAG_W-2:0], rem_ge};
  assign div_done = (dcnt == DCNT_W'(MAG_W - 1));

  // truncation toward zero: divide the magnitude, then restore the sign
  assign quot_ext = POS_W'(num_next);
  assign inc_val  = div_neg ? $signed(-quot_ext) : $signed(quot_ext);

  // ---------------------------------------------------------------------------
  // pixel output
  // ---------------------------------------------------------------------------
  assign out_load = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign is_last  = (cnt == steps - STEP_W'(1));
  // negative positions clamp to zero
  assign pix_x    = px[POS_W-1] ? '0 : px[INC_FRAC+COORD_W-1:INC_FRAC];
  assign pix_y    = py[POS_W-1] ? '0 : py[INC_FRAC+COORD_W-1:INC_FRAC];

  assign s_tready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output register fills on a load, empties on a taken transaction
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= S_STEPS;
        end
        S_STEPS: begin
          // lines below one pixel end here with no output
          if (steps_next == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load && is_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      end_x <= s_tdata[END_W-1:0];
      end_y <= s_tdata[2*END_W-1:END_W];
      color <= s_tdata[2*END_W+COLOR_W-1:2*END_W];
    end

    if (state == S_DIFF) begin
      dx <= dx_next;
      dy <= dy_next;
    end

    if (state == S_STEPS) begin
      steps   <= steps_next;
      num     <= MAG_W'(adx) << SCALE_SH;
      div_neg <= dx[DIFF_W-1];
      rem     <= '0;
      dcnt    <= '0;
    end else if (state == S_DIVX && div_done) begin
      // reload the divider for the y axis
      xinc    <= inc_val;
      num     <= MAG_W'(ady) << SCALE_SH;
      div_neg <= dy[DIFF_W-1];
      rem     <= '0;
      dcnt    <= '0;
    end else if (state == S_DIVX || state == S_DIVY) begin
      num  <= num_next;
      rem  <= rem_next;
      dcnt <= dcnt + DCNT_W'(1);
    end

    if (state == S_DIVY && div_done) begin
      yinc <= inc_val;
      px   <= $signed(POS_W'(origin_x) << INC_FRAC);
      py   <= $signed(POS_W'(origin_y) << INC_FRAC);
      cnt  <= '0;
    end

    if (out_load) begin
      m_tdata <= {{(M_TDATA_W - 2*COORD_W - COLOR_W){1'b0}}, color, pix_y, pix_x};
      m_tlast <= is_last;
      px      <= px + xinc;
      py      <= py + yinc;
      cnt     <= cnt + STEP_W'(1);
    end
  end

endmodule : dda_line_rasterizer

`default_nettype wire

@@ hdl/dda_checker.sv @@
// ----------------------------------------------------------------------------
// dda_checker
// port-level checks for the dda line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module dda_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [dda_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                          m_tlast
);

  import dda_pkg::*;

  // a line in work keeps the slave side closed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted right after a transaction");

  // a pixel that is not the last of its line means the line is still in work
  a_mid_line_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input ready while a line is unfinished");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("pixel dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    else $error("pixel changed while stalled");

endmodule : dda_checker

bind dda_line_rasterizer dda_checker u_dda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/dda_line_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_checker
// pixel stream and register checker for the dda line rasterizer
// ----------------------------------------------------------------------------
// Keeps its own copy of the origin registers from the apb writes it sees,
// expands every accepted endpoint transaction into the pixels the line must
// produce and compares each pixel transaction with the oldest one still owed.
// Register reads are checked against the same copy.

module dda_line_checker
  import dda_pkg::*;
#(
  parameter int MAX_STEPS = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // end_x [17:0], end_y [35:18], pixel_color [59:36], zero [63:60]
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // pixel_x [9:0], pixel_y [19:10], out_color [43:20], zero [47:44]
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  input  logic [PDATA_W-1:0]   prdata,
  input  logic                 pready,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  pixel_t line_pixels[$];
  coord_t org_x;
  coord_t org_y;

  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
  endfunction

  // walk the line in 16-bit fraction fixed point and queue its pixels
  function automatic void trace_line(input logic [END_W-1:0] end_x,
                                     input logic [END_W-1:0] end_y,
                                     input color_t color);
    longint dx, dy, dist_x, dist_y, steps, x_inc, y_inc, x_pos, y_pos, i;
    pixel_t pix;
    dx = longint'(end_x) - (longint'(org_x) <<< FRAC_BITS);
    dy = longint'(end_y) - (longint'(org_y) <<< FRAC_BITS);
    dist_x = dx < 0 ? -dx : dx;
    dist_y = dy < 0 ? -dy : dy;
    steps = (dist_x > dist_y ? dist_x : dist_y) >>> FRAC_BITS;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    if (steps == 0) return;
    // signed division truncates toward zero
    x_inc = (dx <<< (INC_FRAC - FRAC_BITS)) / steps;
    y_inc = (dy <<< (INC_FRAC - FRAC_BITS)) / steps;
    x_pos = longint'(org_x) <<< INC_FRAC;
    y_pos = longint'(org_y) <<< INC_FRAC;
    for (i = 0; i < steps; i++) begin
      pix.x     = x_pos < 0 ? '0 : coord_t'(x_pos >>> INC_FRAC);
      pix.y     = y_pos < 0 ? '0 : coord_t'(y_pos >>> INC_FRAC);
      pix.color = color;
      pix.last  = (i == steps - 1);
      line_pixels.push_back(pix);
      x_pos += x_inc;
      y_pos += y_inc;
    end
  endfunction

  always @(posedge clk) begin : watch
    pixel_t             got;
    pixel_t             want;
    logic [PDATA_W-1:0] reg_val;
    if (rst) begin
      org_x = '0;
      org_y = '0;
      line_pixels.delete();
      mismatches = 0;
    end else begin
      // pixel transaction against the oldest owed pixel
      if (m_tvalid && m_tready) begin
        got.x     = m_tdata[COORD_W-1:0];
        got.y     = m_tdata[2*COORD_W-1:COORD_W];
        got.color = m_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];
        got.last  = m_tlast;
        if (line_pixels.size() == 0) begin
          flag_mismatch($sformatf("pixel with no line owed: x=%0d y=%0d color=%06h last=%0b",
                                  got.x, got.y, got.color, got.last));
        end else begin
          want = line_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.last !== want.last) begin
            flag_mismatch($sformatf({"pixel expected x=%0d y=%0d color=%06h last=%0b, ",
                                     "got x=%0d y=%0d color=%06h last=%0b"},
                                    want.x, want.y, want.color, want.last,
                                    got.x, got.y, got.color, got.last));
          end
        end
      end
      // register access phase
      if (psel && penable && pready) begin
        reg_val = '0;
        reg_val[COORD_W-1:0] = (paddr[2] == REG_ORIGIN_X) ? org_x : org_y;
        if (pwrite) begin
          if (paddr[2] == REG_ORIGIN_X) org_x = pwdata[COORD_W-1:0];
          else org_y = pwdata[COORD_W-1:0];
        end else if (prdata !== reg_val) begin
          flag_mismatch($sformatf("register read at %0h expected %08h, got %08h",
                                  paddr, reg_val, prdata));
        end
      end
      // endpoint transaction
      if (s_tvalid && s_tready) begin
        trace_line(s_tdata[END_W-1:0], s_tdata[2*END_W-1:END_W],
                   s_tdata[2*END_W+COLOR_W-1:2*END_W]);
      end
    end
    pending = line_pixels.size();
  end

endmodule

@@ tb/dda_line_rasterizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb
// stimulus and verdict for the dda line rasterizer
// ----------------------------------------------------------------------------
// Drives endpoint transactions from several origins, first a directed set
// (sub-pixel lines, single steps, exact and capped step counts, every
// direction, screen extremes) and then random lines mostly near the origin.
// Both streams idle in random bursts; origins change through the apb port
// only while the block is idle. The checker beside the block predicts and
// compares every pixel.

module dda_line_rasterizer_tb;
  import dda_pkg::*;

  localparam int MAX_STEPS     = 64;
  localparam int FRAC_BITS     = 8;
  // drain wait covering both divisions plus a full line, with margin
  localparam int DRAIN_CYCLES  = 200;
  localparam int RAND_PHASES   = 6;
  localparam int LINES_PER_PHASE = 41;

  localparam logic [PADDR_W-1:0] ADDR_ORIGIN_X = {REG_ORIGIN_X, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_ORIGIN_Y = {REG_ORIGIN_Y, 2'b00};

  // kinds of random endpoint
  typedef enum int {END_NEAR, END_SUBPIXEL, END_ANYWHERE} end_kind_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // end_x [17:0], end_y [35:18], pixel_color [59:36], zero [63:60]
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // pixel_x [9:0], pixel_y [19:10], out_color [43:20], zero [47:44]
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int mismatches;
  int pending;

  // chance in percent of a sender gap before a line / of a stall burst per cycle
  int gap_pct;
  int stall_pct;
  int stall_left;

  // origin last written, as seen on the apb bus by this module
  coord_t bus_origin_x;
  coord_t bus_origin_y;

  int unsigned gap_by_phase   [RAND_PHASES] = '{25, 40, 0, 30, 15, 0};
  int unsigned stall_by_phase [RAND_PHASES] = '{15, 30, 0, 20, 10, 0};

  dda_line_rasterizer #(
    .MAX_STEPS(MAX_STEPS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dda_line_checker #(
    .MAX_STEPS(MAX_STEPS),
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pixel side back-pressure: stall bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(8, 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // fixed-point endpoint from whole pixels and a fraction
  function automatic logic [END_W-1:0] fx(input int whole, input int frac);
    return END_W'((whole << FRAC_BITS) | frac);
  endfunction

  // register word with the origin in the low bits and noise above
  function automatic logic [PDATA_W-1:0] reg_word(input coord_t v);
    logic [PDATA_W-1:0] w;
    w = $urandom;
    w[COORD_W-1:0] = v;
    return w;
  endfunction

  // random endpoint coordinate around an origin coordinate
  function automatic logic [END_W-1:0] pick_end(input coord_t org, input end_kind_t kind);
    longint v;
    case (kind)
      END_ANYWHERE: return END_W'($urandom);
      END_SUBPIXEL: v = (longint'(org) << FRAC_BITS) + longint'($urandom_range(510)) - 255;
      default:      v = (longint'(org) << FRAC_BITS) + longint'($urandom_range(36000)) - 18000;
    endcase
    if (v < 0) v = 0;
    if (v > (1 << END_W) - 1) v = (1 << END_W) - 1;
    return v[END_W-1:0];
  endfunction

  // one endpoint transaction, entered and left at a falling edge
  task automatic send_line(input logic [END_W-1:0] end_x, input logic [END_W-1:0] end_y,
                           input color_t color);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(9, 1) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, color, end_y, end_x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // setup then access phase; the bus is left selected for a following transfer
  task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                          input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic read_origins();
    apb_xfer(1'b0, ADDR_ORIGIN_X, '0);
    apb_xfer(1'b0, ADDR_ORIGIN_Y, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new origin once every owed pixel is out and a sub-pixel line has settled
  task automatic set_origin(input coord_t ox, input coord_t oy);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_xfer(1'b1, ADDR_ORIGIN_X, reg_word(ox));
    apb_xfer(1'b1, ADDR_ORIGIN_Y, reg_word(oy));
    read_origins();
  endtask

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int        phase;
    int        n;
    coord_t    ox;
    coord_t    oy;
    end_kind_t kind;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    gap_pct   = 30;
    stall_pct = 15;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset origin reads back as zero
    read_origins();

    // origin at the top-left corner
    send_line(fx(0, 0), fx(0, 0), 24'h000000);               // nothing to draw
    send_line(fx(0, 255), fx(0, 255), 24'hFFFFFF);           // just short of one pixel
    send_line(fx(1, 0), fx(0, 0), 24'h123456);               // single pixel along x
    send_line(fx(0, 0), fx(1, 255), 24'hA5A5A5);             // single pixel along y
    send_line(fx(64, 0), fx(5, 128), 24'h5A5A5A);            // exactly the step cap
    send_line(fx(63, 255), fx(0, 0), 24'h0F0F0F);            // one below the cap
    send_line(fx(1023, 255), fx(1023, 255), 24'hFFFFFF);     // far corner, capped
    send_line(fx(65, 0), fx(200, 0), 24'hF0F0F0);            // capped, steep

    // origin at the bottom-right corner: negative directions
    set_origin(10'd1023, 10'd1023);
    send_line(fx(0, 0), fx(0, 0), 24'h000000);
    send_line(fx(1023, 255), fx(1023, 255), 24'hFFFFFF);     // fraction only
    send_line(fx(1022, 0), fx(1023, 0), 24'h00FF00);
    send_line(fx(1000, 55), fx(1023, 255), 24'h0000FF);
    send_line(fx(1023, 0), fx(990, 1), 24'hFF0000);

    // mixed signs from the other two corners
    set_origin(10'd0, 10'd1023);
    send_line(fx(1023, 255), fx(0, 0), 24'h808080);
    send_line(fx(20, 170), fx(1010, 85), 24'h7F7F7F);
    send_line(fx(0, 0), fx(1023, 0), 24'h010101);
    set_origin(10'd1023, 10'd0);
    send_line(fx(959, 0), fx(64, 0), 24'hFEFEFE);
    send_line(fx(1023, 255), fx(1023, 255), 24'h3C3C3C);

    // origin inside the screen
    set_origin(10'd512, 10'd300);
    send_line(fx(480, 128), fx(340, 127), 24'hC3C3C3);
    send_line(fx(512, 0), fx(300, 0), 24'h999999);
    send_line(fx(545, 192), fx(300, 64), 24'h666666);

    // random lines, mostly within reach of the step cap
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       set_origin(10'd1023, 10'd0);
        1:       set_origin(10'd0, 10'd0);
        5:       set_origin(10'd1023, 10'd1023);
        default: set_origin(coord_t'($urandom), coord_t'($urandom));
      endcase
      ox = bus_origin_x;
      oy = bus_origin_y;
      gap_pct   = gap_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      for (n = 0; n < LINES_PER_PHASE; n++) begin
        case ($urandom_range(99) / 10)
          0:       kind = END_SUBPIXEL;
          1:       kind = END_ANYWHERE;
          default: kind = END_NEAR;
        endcase
        send_line(pick_end(ox, kind), pick_end(oy, kind), color_t'($urandom));
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      bus_origin_x <= '0;
      bus_origin_y <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ORIGIN_X) bus_origin_x <= pwdata[COORD_W-1:0];
      else bus_origin_y <= pwdata[COORD_W-1:0];
    end
  end

endmodule

@@ files.f @@
hdl/dda_pkg.sv
hdl/dda_line_rasterizer.sv
hdl/dda_checker.sv
tb/dda_line_checker.sv
tb/dda_line_rasterizer_tb.sv
